>>> src/rfc_pkg.sv
// shared types, constants and helpers of the reference-count heap collector
package rfc_pkg;

    localparam int HEAP_DEPTH  = 2048;
    localparam int COUNT_BITS  = 8;
    localparam int NUM_HANDLES = 2048;
    localparam int HANDLE_W    = 11;
    localparam int POS_W       = $clog2(HEAP_DEPTH);
    localparam int OCC_W       = POS_W + 1;
    localparam int CHILD_W     = POS_W + 2;
    localparam int COUNT_MAX   = (1 << COUNT_BITS) - 1;
    localparam int HEAP_W      = HANDLE_W + COUNT_BITS;

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [HANDLE_W-1:0]   handle_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [OCC_W-1:0]      occ_t;
    typedef logic [CHILD_W-1:0]    child_t;

    // one heap position: handle and its count
    typedef struct packed {
        handle_t h;
        cnt_t    c;
    } heap_ent_t;

    // item modes
    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_INC     = 2'd1;
    localparam logic [1:0] MODE_DEC     = 2'd2;
    localparam logic [1:0] MODE_COLLECT = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_DONE    = 3'd0;
    localparam logic [2:0] STAT_IGNORED = 3'd1;
    localparam logic [2:0] STAT_FREED   = 3'd2;
    localparam logic [2:0] STAT_NOFREE  = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;

    // saturate an 8-bit start count to the count width
    function automatic cnt_t sat_start(logic [7:0] v);
        if (32'(v) > COUNT_MAX) begin
            return cnt_t'(COUNT_MAX);
        end
        return cnt_t'(v);
    endfunction

endpackage

>>> src/rfc_ram.sv
// generic single-write, single-read ram with registered read data
module rfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/refcount_min_heap_collector.sv
// top level: indexed min-heap of handles keyed by reference count
//
// Usage: one input channel (s_*) carries transactions with a mode, a handle,
// a start count and an exempt flag; one result channel (m_*) returns exactly
// one transaction per input with a status, a freed handle and a count.
// The heap lives in a ram of {handle, count} per position; a second ram maps
// each handle to its position. A handle counts as present when its mapped
// position lies below the fill level and that position holds the handle,
// so no clearing pass is needed after reset.
// Sequence: an exempt item goes straight to the result state; otherwise a lookup
// (ST_LOOK, ST_CHK) leads to sift-up levels (ST_UP_RD, ST_UP_CMP) or sift-down
// levels (ST_DN_RD, ST_DN_RD2, ST_DN_CMP; one ram read port, children read one
// after the other), then a final write and the result state ST_FIN.
// One item is processed at a time; the next is taken once the sequencer
// returns to idle, even while the previous result still waits in the
// output register.
// Reset (aresetn low, synchronous) empties the heap and drops any result.
// When the receiver stalls, the result is held and the sequencer waits in
// its final state until the output register frees.
module refcount_min_heap_collector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [10:0] s_handle,
    input  logic [7:0]  s_start_count,
    input  logic        s_exempt,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [10:0] m_freed_handle,
    output logic [7:0]  m_count_after
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_LOOK   = 10'b0000000010,
        ST_CHK    = 10'b0000000100,
        ST_UP_RD  = 10'b0000001000,
        ST_UP_CMP = 10'b0000010000,
        ST_DN_RD  = 10'b0000100000,
        ST_DN_RD2 = 10'b0001000000,
        ST_DN_CMP = 10'b0010000000,
        ST_LAST   = 10'b0100000000,
        ST_FIN    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]          mode_reg, mode_next;
    rfc_pkg::handle_t    h_reg, h_next;
    rfc_pkg::cnt_t       start_reg, start_next;
    rfc_pkg::heap_ent_t  ent_reg, ent_next;
    rfc_pkg::heap_ent_t  left_reg, left_next;
    logic                right_ok_reg, right_ok_next;
    rfc_pkg::pos_t       pos_reg, pos_next;
    rfc_pkg::occ_t       occ_reg, occ_next;
    logic [2:0]          res_status_reg, res_status_next;
    rfc_pkg::handle_t    res_freed_reg, res_freed_next;
    rfc_pkg::cnt_t       res_cnt_reg, res_cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [2:0]          out_status_reg, out_status_next;
    rfc_pkg::handle_t    out_freed_reg, out_freed_next;
    logic [7:0]          out_cnt_reg, out_cnt_next;

    // ram ports
    logic                heap_we;
    rfc_pkg::pos_t       heap_waddr, heap_raddr;
    rfc_pkg::heap_ent_t  heap_wdata, heap_rdata;
    logic                slot_we;
    rfc_pkg::handle_t    slot_waddr, slot_raddr;
    rfc_pkg::pos_t       slot_wdata, slot_rdata;

    // tree navigation
    rfc_pkg::pos_t       parent;
    rfc_pkg::child_t     left, right;
    rfc_pkg::heap_ent_t  pick;
    rfc_pkg::child_t     pick_pos;
    logic                s_fire;
    rfc_pkg::occ_t       occ_dec;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign parent  = rfc_pkg::pos_t'((pos_reg - 1'b1) >> 1);
    assign left    = rfc_pkg::child_t'({pos_reg, 1'b1});
    assign right   = left + 1'b1;
    assign occ_dec = occ_reg - 1'b1;

    // smaller child, left on a tie
    always_comb begin
        pick     = left_reg;
        pick_pos = left;
        if (right_ok_reg && (heap_rdata.c < left_reg.c)) begin
            pick     = heap_rdata;
            pick_pos = right;
        end
    end

    rfc_ram #(
        .WIDTH(rfc_pkg::HEAP_W),
        .DEPTH(rfc_pkg::HEAP_DEPTH)
    ) u_heap_ram (
        .aclk (aclk),
        .we   (heap_we),
        .waddr(heap_waddr),
        .wdata(heap_wdata),
        .raddr(heap_raddr),
        .rdata(heap_rdata)
    );

    rfc_ram #(
        .WIDTH(rfc_pkg::POS_W),
        .DEPTH(rfc_pkg::NUM_HANDLES)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(slot_wdata),
        .raddr(slot_raddr),
        .rdata(slot_rdata)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        h_next          = h_reg;
        start_next      = start_reg;
        ent_next        = ent_reg;
        left_next       = left_reg;
        right_ok_next   = right_ok_reg;
        pos_next        = pos_reg;
        occ_next        = occ_reg;
        res_status_next = res_status_reg;
        res_freed_next  = res_freed_reg;
        res_cnt_next    = res_cnt_reg;
        m_valid_next    = m_valid_reg;
        out_status_next = out_status_reg;
        out_freed_next  = out_freed_reg;
        out_cnt_next    = out_cnt_reg;

        heap_we    = 1'b0;
        heap_waddr = pos_reg;
        heap_wdata = ent_reg;
        heap_raddr = '0;
        slot_we    = 1'b0;
        slot_waddr = ent_reg.h;
        slot_wdata = pos_reg;
        slot_raddr = s_handle;

        // result register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                heap_raddr = '0;
                slot_raddr = s_handle;
                if (s_fire) begin
                    mode_next       = s_mode;
                    h_next          = s_handle;
                    start_next      = rfc_pkg::sat_start(s_start_count);
                    res_status_next = rfc_pkg::STAT_IGNORED;
                    res_freed_next  = '0;
                    res_cnt_next    = '0;
                    state_next      = s_exempt ? ST_FIN : ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (mode_reg == rfc_pkg::MODE_COLLECT) begin
                    // root entry is on the read port
                    heap_raddr = occ_dec[rfc_pkg::POS_W-1:0];
                    if (occ_reg == '0) begin
                        res_status_next = rfc_pkg::STAT_NOFREE;
                        state_next      = ST_FIN;
                    end else if (heap_rdata.c != '0) begin
                        res_status_next = rfc_pkg::STAT_NOFREE;
                        res_cnt_next    = heap_rdata.c;
                        state_next      = ST_FIN;
                    end else begin
                        res_status_next = rfc_pkg::STAT_FREED;
                        res_freed_next  = heap_rdata.h;
                        occ_next        = occ_dec;
                        state_next      = (occ_dec != '0) ? ST_LAST : ST_FIN;
                    end
                end else begin
                    heap_raddr = slot_rdata;
                    pos_next   = slot_rdata;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if ((rfc_pkg::occ_t'(pos_reg) < occ_reg) && (heap_rdata.h == h_reg)) begin
                    if (mode_reg == rfc_pkg::MODE_INSERT) begin
                        state_next = ST_FIN;
                    end else begin
                        ent_next.h      = h_reg;
                        ent_next.c      = heap_rdata.c;
                        res_status_next = rfc_pkg::STAT_DONE;
                        if (mode_reg == rfc_pkg::MODE_INC) begin
                            if (heap_rdata.c != '1) begin
                                ent_next.c = heap_rdata.c + 1'b1;
                            end
                            state_next = ST_DN_RD;
                        end else begin
                            if (heap_rdata.c != '0) begin
                                ent_next.c = heap_rdata.c - 1'b1;
                            end
                            state_next = ST_UP_RD;
                        end
                        res_cnt_next = ent_next.c;
                    end
                end else if (mode_reg == rfc_pkg::MODE_INSERT) begin
                    if (occ_reg >= rfc_pkg::occ_t'(rfc_pkg::HEAP_DEPTH)) begin
                        res_status_next = rfc_pkg::STAT_FULL;
                        res_cnt_next    = start_reg;
                        state_next      = ST_FIN;
                    end else begin
                        res_status_next = rfc_pkg::STAT_DONE;
                        res_cnt_next    = start_reg;
                        ent_next.h      = h_reg;
                        ent_next.c      = start_reg;
                        pos_next        = occ_reg[rfc_pkg::POS_W-1:0];
                        occ_next        = occ_reg + 1'b1;
                        state_next      = ST_UP_RD;
                    end
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_LAST: begin
                // last entry moves to the root
                ent_next   = heap_rdata;
                pos_next   = '0;
                state_next = ST_DN_RD;
            end
            ST_UP_RD: begin
                heap_raddr = parent;
                if (pos_reg == '0) begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (heap_rdata.c > ent_reg.c) begin
                    // parent moves down into the hole
                    heap_wdata = heap_rdata;
                    slot_waddr = heap_rdata.h;
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DN_RD: begin
                heap_raddr = left[rfc_pkg::POS_W-1:0];
                if (left >= rfc_pkg::child_t'(occ_reg)) begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_DN_RD2;
                end
            end
            ST_DN_RD2: begin
                heap_raddr    = right[rfc_pkg::POS_W-1:0];
                left_next     = heap_rdata;
                right_ok_next = (right < rfc_pkg::child_t'(occ_reg));
                state_next    = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
                if (ent_reg.c > pick.c) begin
                    // smaller child moves up into the hole
                    heap_wdata = pick;
                    slot_waddr = pick.h;
                    pos_next   = pick_pos[rfc_pkg::POS_W-1:0];
                    state_next = ST_DN_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_freed_next  = res_freed_reg;
                    out_cnt_next    = 8'(res_cnt_reg);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        h_reg          <= h_next;
        start_reg      <= start_next;
        ent_reg        <= ent_next;
        left_reg       <= left_next;
        right_ok_reg   <= right_ok_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_freed_reg  <= res_freed_next;
        res_cnt_reg    <= res_cnt_next;
        out_status_reg <= out_status_next;
        out_freed_reg  <= out_freed_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_status_reg;
    assign m_freed_handle = out_freed_reg;
    assign m_count_after  = out_cnt_reg;

    // fill level stays within the heap
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= rfc_pkg::occ_t'(rfc_pkg::HEAP_DEPTH))
        else $error("heap fill level beyond depth");

    // heap and slot maps are always updated together
    assert property (@(posedge aclk) heap_we == slot_we)
        else $error("heap and slot writes out of step");

    // an accepted transaction blocks the input until done
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input accepted while busy");

    // a result appears only from the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside final state");

endmodule

>>> sim/tb.sv
// self-checking testbench of the reference-count heap collector
`timescale 1ns / 1ps

module tb;

    localparam int NH = 2048;

    // result record
    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] freed;
        logic [7:0]  cnt;
    } heap_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = rfc_pkg::MODE_INSERT;
    logic [10:0] s_handle = '0;
    logic [7:0]  s_start_count = '0;
    logic        s_exempt = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [10:0] m_freed_handle;
    logic [7:0]  m_count_after;

    refcount_min_heap_collector DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_handle(s_handle), .s_start_count(s_start_count), .s_exempt(s_exempt),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_freed_handle(m_freed_handle), .m_count_after(m_count_after)
    );

    always #2 aclk = ~aclk;

    // shadow heap state
    logic [10:0] heap_h [NH];
    logic [10:0] pos_of [NH];
    logic [7:0]  cnt_of [NH];
    bit          present [NH];
    int unsigned fill;

    heap_result_t pending_results[$];
    int  mismatches;
    bit  idle_on = 1'b1;

    function automatic logic [7:0] key_at(int unsigned p);
        return cnt_of[heap_h[p]];
    endfunction

    function automatic void swap_pos(int unsigned a, int unsigned b);
        logic [10:0] ha, hb;
        ha = heap_h[a];
        hb = heap_h[b];
        heap_h[a] = hb;
        heap_h[b] = ha;
        pos_of[hb] = 11'(a);
        pos_of[ha] = 11'(b);
    endfunction

    function automatic void bubble_up(int unsigned p);
        int unsigned par;
        while (p > 0 && p < fill) begin
            par = (p - 1) / 2;
            if (key_at(p) >= key_at(par)) break;
            swap_pos(p, par);
            p = par;
        end
    endfunction

    function automatic void bubble_down(int unsigned p);
        int unsigned l, pick;
        while (p < fill) begin
            l = 2 * p + 1;
            if (l >= fill) break;
            pick = l;
            if (l + 1 < fill && key_at(l + 1) < key_at(l)) pick = l + 1;
            if (key_at(p) <= key_at(pick)) break;
            swap_pos(p, pick);
            p = pick;
        end
    endfunction

    // compute the result of one transaction and update the shadow heap
    function automatic heap_result_t predict_heap_op(logic [1:0] md, logic [10:0] h,
                                                     logic [7:0] st, logic ex);
        heap_result_t r;
        logic [10:0] root, mv;
        logic [7:0]  c;
        r.status = rfc_pkg::STAT_IGNORED;
        r.freed = '0;
        r.cnt = '0;
        if (!ex) begin
            case (md)
                rfc_pkg::MODE_INSERT: begin
                    if (present[h]) begin
                        r.status = rfc_pkg::STAT_IGNORED;
                    end else if (fill >= rfc_pkg::HEAP_DEPTH) begin
                        r.status = rfc_pkg::STAT_FULL;
                        r.cnt = st;
                    end else begin
                        heap_h[fill] = h;
                        pos_of[h] = 11'(fill);
                        cnt_of[h] = st;
                        present[h] = 1'b1;
                        fill++;
                        bubble_up(fill - 1);
                        r.status = rfc_pkg::STAT_DONE;
                        r.cnt = st;
                    end
                end
                rfc_pkg::MODE_INC, rfc_pkg::MODE_DEC: begin
                    if (present[h]) begin
                        c = cnt_of[h];
                        if (md == rfc_pkg::MODE_INC) begin
                            if (c != 8'hFF) c++;
                            cnt_of[h] = c;
                            bubble_down(pos_of[h]);
                        end else begin
                            if (c != 0) c--;
                            cnt_of[h] = c;
                            bubble_up(pos_of[h]);
                        end
                        r.status = rfc_pkg::STAT_DONE;
                        r.cnt = c;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        r.status = rfc_pkg::STAT_NOFREE;
                    end else if (key_at(0) != 0) begin
                        r.status = rfc_pkg::STAT_NOFREE;
                        r.cnt = key_at(0);
                    end else begin
                        root = heap_h[0];
                        present[root] = 1'b0;
                        if (fill > 1) begin
                            mv = heap_h[fill - 1];
                            heap_h[0] = mv;
                            pos_of[mv] = 0;
                        end
                        fill--;
                        bubble_down(0);
                        r.status = rfc_pkg::STAT_FREED;
                        r.freed = root;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // send one transaction, with an optional random gap before it
    task automatic send_op(logic [1:0] md, logic [10:0] h, logic [7:0] st, logic ex);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_handle <= h;
        s_start_count <= st;
        s_exempt <= ex;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_heap_op(md, h, st, ex));
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        heap_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result status=%0d", m_status);
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.status !== m_status || exp_r.freed !== m_freed_handle ||
                    exp_r.cnt !== m_count_after) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d fh=%0d c=%0d got st=%0d fh=%0d c=%0d",
                                 exp_r.status, exp_r.freed, exp_r.cnt,
                                 m_status, m_freed_handle, m_count_after);
                end
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(posedge aclk);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // pick a handle from a small pool so hits are common
    function automatic logic [10:0] pick_handle();
        if ($urandom_range(0, 9) == 0) return 11'($urandom_range(0, 2047));
        return 11'($urandom_range(0, 63)) | ($urandom_range(0, 1) ? 11'h7C0 : 11'h000);
    endfunction

    task automatic test_directed();
        send_op(rfc_pkg::MODE_COLLECT, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INC, 11'd5, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_DEC, 11'd5, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd2047, 8'd255, 1'b0);
        send_op(rfc_pkg::MODE_COLLECT, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INC, 11'd2047, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd2047, 8'd3, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd1, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd2, 8'd7, 1'b0);
        send_op(rfc_pkg::MODE_DEC, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd3, 8'd0, 1'b1);
        send_op(rfc_pkg::MODE_COLLECT, 11'd0, 8'd0, 1'b1);
        send_op(rfc_pkg::MODE_INC, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_DEC, 11'd2, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_COLLECT, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_COLLECT, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_DEC, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_COLLECT, 11'd0, 8'd0, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd1365, 8'h55, 1'b0);
        send_op(rfc_pkg::MODE_INSERT, 11'd682, 8'hAA, 1'b0);
        stop_sending();
        drain_results();
    endtask

    task automatic test_random_ops(int n);
        logic [1:0] md;
        for (int i = 0; i < n; i++) begin
            md = 2'($urandom_range(0, 3));
            send_op(md, pick_handle(), 8'($urandom_range(0, 255)) & ($urandom_range(0, 1) ?
                    8'hFF : 8'h03), ($urandom_range(0, 19) == 0));
        end
        stop_sending();
        drain_results();
    endtask

    // fill the heap to capacity, then work deep sifts on the full heap
    task automatic test_full_heap();
        for (int h = 0; h < NH; h++) begin
            if (h >= NH - NH / 4) idle_on = 1'b0;
            if (!present[h]) begin
                send_op(rfc_pkg::MODE_INSERT, 11'(h), $urandom_range(0, 1) ?
                        8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3)), 1'b0);
            end
        end
        send_op(rfc_pkg::MODE_INSERT, 11'd9, 8'd200, 1'b0);
        for (int i = 0; i < 80; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_op($urandom_range(0, 1) ? rfc_pkg::MODE_DEC : rfc_pkg::MODE_INC,
                        11'($urandom_range(0, 2047)), 8'd0, 1'b0);
            end else if (fill > 0 && key_at(0) != 0) begin
                send_op(rfc_pkg::MODE_DEC, heap_h[0], 8'd0, 1'b0);
            end else begin
                send_op(rfc_pkg::MODE_COLLECT, 11'd0, 8'd0, 1'b0);
            end
        end
        stop_sending();
        drain_results();
    endtask

    initial begin
        fill = 0;
        mismatches = 0;
        for (int i = 0; i < NH; i++) present[i] = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_ops(120);
        test_full_heap();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
src/rfc_pkg.sv
src/rfc_ram.sv
src/refcount_min_heap_collector.sv
sim/tb.sv
